[hw/rtl/http_response_body_extractor_top_assert.svh]
// ----------------------------------------------------------------------------
// http_response_body_extractor_top_assert
// assertion macros for the http response body extractor
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_BODY_EXTRACTOR_TOP_ASSERT_SVH
`define HTTP_RESPONSE_BODY_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define HRBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define HRBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HRBE_ASSERT(lbl, prop, msg)
`define HRBE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/hrbe_pkg.sv]
// ----------------------------------------------------------------------------
// hrbe_pkg
// types, character codes and match tables of the http response body extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrbe_pkg;

  localparam int HRBE_LENGTH_BITS = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_C     = 8'h63;

  localparam logic [2:0] PREFIX_LEN  = 3'd5;
  localparam logic [2:0] CHUNKED_LEN = 3'd7;
  localparam logic [4:0] CL_LEN      = 5'd14;
  localparam logic [4:0] TE_LEN      = 5'd17;
  localparam logic [4:0] KEY_LEN_MAX = 5'd31;

  localparam logic [9:0] STATUS_MAX = 10'd999;

  localparam logic [1:0] KF_NONE = 2'd0;
  localparam logic [1:0] KF_CL   = 2'd1;
  localparam logic [1:0] KF_TE   = 2'd2;
  localparam logic [1:0] KF_BOTH = 2'd3;

  // result kinds
  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'd0,
    PH_SEEK   = 4'd1,
    PH_DIGITS = 4'd2,
    PH_REST   = 4'd3,
    PH_KEY    = 4'd4,
    PH_VALUE  = 4'd5,
    PH_BLEN   = 4'd6,
    PH_STREAM = 4'd7,
    PH_CSIZE  = 4'd8,
    PH_CEXT   = 4'd9,
    PH_CDATA  = 4'd10,
    PH_CTRAIL = 4'd11,
    PH_DONE   = 4'd12,
    PH_ERROR  = 4'd13
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [9:0]  resp_status;
    logic        outcome;
    logic        was_chunked;
    logic [31:0] body_count;
    logic        is_last;
  } res_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "H";
      3'd1: c = "T";
      3'd2: c = "T";
      3'd3: c = "P";
      3'd4: c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0:  c = "c";
      5'd1:  c = "o";
      5'd2:  c = "n";
      5'd3:  c = "t";
      5'd4:  c = "e";
      5'd5:  c = "n";
      5'd6:  c = "t";
      5'd7:  c = "-";
      5'd8:  c = "l";
      5'd9:  c = "e";
      5'd10: c = "n";
      5'd11: c = "g";
      5'd12: c = "t";
      5'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0:  c = "t";
      5'd1:  c = "r";
      5'd2:  c = "a";
      5'd3:  c = "n";
      5'd4:  c = "s";
      5'd5:  c = "f";
      5'd6:  c = "e";
      5'd7:  c = "r";
      5'd8:  c = "-";
      5'd9:  c = "e";
      5'd10: c = "n";
      5'd11: c = "c";
      5'd12: c = "o";
      5'd13: c = "d";
      5'd14: c = "i";
      5'd15: c = "n";
      5'd16: c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] chk_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "c";
      3'd1: c = "h";
      3'd2: c = "u";
      3'd3: c = "n";
      3'd4: c = "k";
      3'd5: c = "e";
      3'd6: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/http_response_body_extractor_top.sv]
// ----------------------------------------------------------------------------
// http_response_body_extractor_top
// streaming http/1.1 response parser: status line, content-length and
// chunked transfer decoding, one body byte per result plus an end summary
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register until all its results
//   fit, then is parsed into the result queue, whose head drives the output
// throughput: one byte per cycle while its results fit in the queue; a final
//   byte with a body result needs two output beats, the queue absorbs the
//   extra one, and while the queue stays full a further two-beat byte stalls
// rate is set by the two-entry result queue behind the single parse stage
// reset: synchronous active-high rst clears the handshake and parser state
`timescale 1ns / 1ps

`include "http_response_body_extractor_top_assert.svh"

module http_response_body_extractor_top
  import hrbe_pkg::*;
#(
  parameter int LENGTH_BITS = HRBE_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_response,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  body_byte,
  output logic [9:0]  resp_status,
  output logic        outcome,
  output logic        was_chunked,
  output logic [31:0] body_count,
  output logic        is_last
);

  localparam int L = LENGTH_BITS;

  // --------------------------------------------------------------------------
  // input register: one beat waits here while it is parsed
  // --------------------------------------------------------------------------
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eor;
  logic       in_accept;
  logic       fire;

  assign in_stall  = in_full && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte <= data_byte;
      in_eor  <= end_of_response;
    end
  end

  // --------------------------------------------------------------------------
  // parser state
  // --------------------------------------------------------------------------
  phase_t        phase, phase_next;
  logic [2:0]    match_pos, match_pos_next;
  logic [9:0]    status_value, status_value_next;
  logic [1:0]    key_flags, key_flags_next;
  logic [4:0]    key_length, key_length_next;
  logic [L-1:0]  length_value, length_value_next;
  logic          have_length, have_length_next;
  logic          chunked_flag, chunked_flag_next;
  logic [L-1:0]  chunk_left, chunk_left_next;
  logic          pending_cr, pending_cr_next;
  logic [31:0]   emitted_count, emitted_count_next;
  logic          emit;

  // --------------------------------------------------------------------------
  // per-byte decode, shared by several phases
  // --------------------------------------------------------------------------
  logic          is_digit;
  logic [3:0]    dig;
  logic          hex_ok;
  logic [3:0]    hex_v;
  logic [7:0]    lc;
  logic [13:0]   st_prod;
  logic [9:0]    status_acc;
  logic [L+3:0]  len_prod;
  logic [L-1:0]  len_acc;
  logic [L-1:0]  csz_base;
  logic [L-1:0]  csz_acc;
  logic          csz_first;
  logic          lf_after_cr;

  assign is_digit    = (in_byte >= "0") && (in_byte <= "9");
  assign dig         = in_byte[3:0];
  assign lf_after_cr = pending_cr && (in_byte == CH_LF);

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (is_digit) begin
      hex_v = in_byte[3:0];
    end else if ((in_byte >= "a" && in_byte <= "f") || (in_byte >= "A" && in_byte <= "F")) begin
      // low three bits of a-f and A-F run 1..6
      hex_v = 4'd9 + {1'b0, in_byte[2:0]};
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign lc = (in_byte >= "A" && in_byte <= "Z") ? (in_byte + 8'd32) : in_byte;

  // status digits: value*10 + d, clamped
  assign st_prod    = ({4'd0, status_value} << 3) + ({4'd0, status_value} << 1)
                    + {10'd0, dig};
  assign status_acc = (st_prod > {4'd0, STATUS_MAX}) ? STATUS_MAX : st_prod[9:0];

  // content-length digits: value*10 + d, saturating at the field width
  assign len_prod = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1)
                  + {{L{1'b0}}, dig};
  assign len_acc  = (len_prod[L+3:L] != 4'd0) ? {L{1'b1}} : len_prod[L-1:0];

  // chunk size digits: a chunk trailer byte that is not cr starts a fresh size
  assign csz_first = (phase == PH_CTRAIL);
  assign csz_base  = csz_first ? '0 : chunk_left;
  assign csz_acc   = (csz_base[L-1:L-4] != 4'd0) ? {L{1'b1}} : {csz_base[L-5:0], hex_v};

  // --------------------------------------------------------------------------
  // next-state logic for one byte
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next         = phase;
    match_pos_next     = match_pos;
    status_value_next  = status_value;
    key_flags_next     = key_flags;
    key_length_next    = key_length;
    length_value_next  = length_value;
    have_length_next   = have_length;
    chunked_flag_next  = chunked_flag;
    chunk_left_next    = chunk_left;
    pending_cr_next    = pending_cr;
    emit               = 1'b0;

    case (phase)
      PH_PREFIX: begin
        if (in_byte == prefix_char(match_pos)) begin
          match_pos_next = match_pos + 3'd1;
          if (match_pos + 3'd1 == PREFIX_LEN) begin
            phase_next     = PH_SEEK;
            match_pos_next = 3'd0;
          end
        end else begin
          phase_next = PH_ERROR;
        end
      end

      PH_SEEK, PH_DIGITS, PH_REST: begin
        if (lf_after_cr) begin
          pending_cr_next = 1'b0;
          if (status_value == 10'd0) begin
            phase_next = PH_ERROR;
          end else begin
            phase_next      = PH_KEY;
            key_length_next = 5'd0;
            key_flags_next  = KF_BOTH;
            match_pos_next  = 3'd0;
          end
        end else begin
          if (phase == PH_SEEK) begin
            if (in_byte == CH_SP) begin
              phase_next     = PH_DIGITS;
              match_pos_next = 3'd0;
            end
          end else if (phase == PH_DIGITS) begin
            if (is_digit) begin
              status_value_next = status_acc;
              match_pos_next    = 3'd1;
            end else if (!(match_pos == 3'd0 && (in_byte == CH_SP || in_byte == CH_TAB))) begin
              phase_next = PH_REST;
            end
          end
          pending_cr_next = (in_byte == CH_CR);
        end
      end

      PH_KEY: begin
        if (lf_after_cr) begin
          pending_cr_next = 1'b0;
          if (key_length == 5'd1) begin
            // blank line: pick the body mode
            match_pos_next = 3'd0;
            if (chunked_flag) begin
              phase_next      = PH_CSIZE;
              chunk_left_next = '0;
            end else if (have_length) begin
              phase_next = (length_value != '0) ? PH_BLEN : PH_DONE;
            end else begin
              phase_next = PH_STREAM;
            end
          end else begin
            key_length_next = 5'd0;
            key_flags_next  = KF_BOTH;
            match_pos_next  = 3'd0;
          end
        end else begin
          if (in_byte == CH_COLON) begin
            if (key_flags[0] && key_length == CL_LEN) begin
              key_flags_next    = KF_CL;
              have_length_next  = 1'b1;
              length_value_next = '0;
            end else if (key_flags[1] && key_length == TE_LEN) begin
              key_flags_next = KF_TE;
            end else begin
              key_flags_next = KF_NONE;
            end
            match_pos_next = 3'd0;
            phase_next     = PH_VALUE;
          end else begin
            key_flags_next[0] = key_flags[0] && (key_length < CL_LEN)
                              && (lc == cl_char(key_length));
            key_flags_next[1] = key_flags[1] && (key_length < TE_LEN)
                              && (lc == te_char(key_length));
            if (key_length < KEY_LEN_MAX) begin
              key_length_next = key_length + 5'd1;
            end
          end
          pending_cr_next = (in_byte == CH_CR);
        end
      end

      PH_VALUE: begin
        if (lf_after_cr) begin
          pending_cr_next = 1'b0;
          phase_next      = PH_KEY;
          key_length_next = 5'd0;
          key_flags_next  = KF_BOTH;
          match_pos_next  = 3'd0;
        end else begin
          if (key_flags == KF_CL) begin
            if (match_pos == 3'd0 && in_byte == CH_SP) begin
              match_pos_next = match_pos;
            end else if (match_pos < 3'd2 && is_digit) begin
              length_value_next = len_acc;
              match_pos_next    = 3'd1;
            end else begin
              match_pos_next = 3'd2;
            end
          end else if (key_flags == KF_TE && match_pos < CHUNKED_LEN) begin
            if (in_byte == chk_char(match_pos)) begin
              match_pos_next = match_pos + 3'd1;
              if (match_pos + 3'd1 == CHUNKED_LEN) begin
                chunked_flag_next = 1'b1;
              end
            end else begin
              match_pos_next = (in_byte == CH_C) ? 3'd1 : 3'd0;
            end
          end
          pending_cr_next = (in_byte == CH_CR);
        end
      end

      PH_BLEN: begin
        length_value_next = length_value - {{(L-1){1'b0}}, 1'b1};
        if (length_value == {{(L-1){1'b0}}, 1'b1}) begin
          phase_next = PH_DONE;
        end
        emit = 1'b1;
      end

      PH_STREAM: begin
        emit = 1'b1;
      end

      PH_CSIZE, PH_CTRAIL: begin
        if (phase == PH_CTRAIL && pending_cr) begin
          pending_cr_next = 1'b0;
          if (in_byte == CH_LF) begin
            phase_next      = PH_CSIZE;
            chunk_left_next = '0;
            match_pos_next  = 3'd0;
          end else begin
            phase_next = PH_DONE;
          end
        end else if (phase == PH_CTRAIL && in_byte == CH_CR) begin
          pending_cr_next = 1'b1;
        end else begin
          // size digit; a trailer byte restarts the size field first
          if (hex_ok) begin
            chunk_left_next = csz_acc;
            match_pos_next  = 3'd1;
            phase_next      = PH_CSIZE;
          end else if (csz_first || match_pos == 3'd0) begin
            phase_next = PH_DONE;
            if (csz_first) begin
              chunk_left_next = '0;
              match_pos_next  = 3'd0;
            end
          end else begin
            phase_next      = PH_CEXT;
            pending_cr_next = (in_byte == CH_CR);
          end
        end
      end

      PH_CEXT: begin
        if (lf_after_cr) begin
          pending_cr_next = 1'b0;
          phase_next      = (chunk_left != '0) ? PH_CDATA : PH_DONE;
        end else begin
          pending_cr_next = (in_byte == CH_CR);
        end
      end

      PH_CDATA: begin
        chunk_left_next = chunk_left - {{(L-1){1'b0}}, 1'b1};
        if (chunk_left == {{(L-1){1'b0}}, 1'b1}) begin
          phase_next      = PH_CTRAIL;
          pending_cr_next = 1'b0;
        end
        emit = 1'b1;
      end

      default: begin
        phase_next = phase;
      end
    endcase
  end

  assign emitted_count_next = (emit && emitted_count != 32'hFFFF_FFFF)
                            ? emitted_count + 32'd1 : emitted_count;

  // --------------------------------------------------------------------------
  // results of this byte
  // --------------------------------------------------------------------------
  res_t       res_body;
  res_t       res_sum;
  logic       bad;
  logic [1:0] nres;

  assign bad = (phase_next == PH_PREFIX) || (phase_next == PH_SEEK)
            || (phase_next == PH_DIGITS) || (phase_next == PH_REST)
            || (phase_next == PH_ERROR);

  always_comb begin
    res_body.kind        = KIND_BODY;
    res_body.body_byte   = in_byte;
    res_body.resp_status = status_value_next;
    res_body.outcome     = 1'b0;
    res_body.was_chunked = chunked_flag_next;
    res_body.body_count  = emitted_count_next;
    res_body.is_last     = 1'b0;

    res_sum.kind         = KIND_SUMMARY;
    res_sum.body_byte    = 8'd0;
    res_sum.resp_status  = bad ? 10'd0 : status_value_next;
    res_sum.outcome      = bad;
    res_sum.was_chunked  = chunked_flag_next;
    res_sum.body_count   = emitted_count_next;
    res_sum.is_last      = 1'b1;
  end

  assign nres = {1'b0, emit} + {1'b0, in_eor};

  // --------------------------------------------------------------------------
  // result queue: two entries, head at index 0
  // --------------------------------------------------------------------------
  res_t       q [2];
  res_t       q_next [2];
  logic [1:0] q_count, q_count_next;
  logic       pop;
  logic [1:0] room;

  assign out_valid = (q_count != 2'd0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    case (q_count)
      2'd0:    room = 2'd2;
      2'd1:    room = pop ? 2'd2 : 2'd1;
      2'd2:    room = pop ? 2'd1 : 2'd0;
      default: room = 2'd0;
    endcase
  end

  // a byte is parsed only when all its results fit
  assign fire = in_full && (nres <= room);

  always_comb begin
    q_next[0]    = q[0];
    q_next[1]    = q[1];
    q_count_next = q_count;
    if (pop) begin
      q_next[0]    = q[1];
      q_count_next = q_count - 2'd1;
    end
    if (fire && nres != 2'd0) begin
      q_next[q_count_next[0]] = emit ? res_body : res_sum;
      q_count_next            = q_count_next + 2'd1;
      if (nres == 2'd2) begin
        q_next[q_count_next[0]] = res_sum;
        q_count_next            = q_count_next + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      q_count <= q_count_next;
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  assign kind        = q[0].kind;
  assign body_byte   = q[0].body_byte;
  assign resp_status = q[0].resp_status;
  assign outcome     = q[0].outcome;
  assign was_chunked = q[0].was_chunked;
  assign body_count  = q[0].body_count;
  assign is_last     = q[0].is_last;

  // --------------------------------------------------------------------------
  // parser state register; the final byte of a response restarts the parser
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || (fire && in_eor)) begin
      phase         <= PH_PREFIX;
      match_pos     <= 3'd0;
      status_value  <= 10'd0;
      key_flags     <= KF_NONE;
      key_length    <= 5'd0;
      length_value  <= '0;
      have_length   <= 1'b0;
      chunked_flag  <= 1'b0;
      chunk_left    <= '0;
      pending_cr    <= 1'b0;
      emitted_count <= 32'd0;
    end else if (fire) begin
      phase         <= phase_next;
      match_pos     <= match_pos_next;
      status_value  <= status_value_next;
      key_flags     <= key_flags_next;
      key_length    <= key_length_next;
      length_value  <= length_value_next;
      have_length   <= have_length_next;
      chunked_flag  <= chunked_flag_next;
      chunk_left    <= chunk_left_next;
      pending_cr    <= pending_cr_next;
      emitted_count <= emitted_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `HRBE_ASSERT_ALWAYS(a_reset_clears, rst |=> (q_count == 2'd0 && !in_full), "reset left beats")
  `HRBE_ASSERT(a_queue_bound, q_count != 2'd3, "result queue overflow")
  `HRBE_ASSERT(a_end_restarts, (fire && in_eor) |=> (phase == PH_PREFIX), "no restart after end")
  `HRBE_ASSERT(a_held_byte, (in_full && !fire) |=> (in_full && $stable(in_byte)), "beat lost")

endmodule
